>>> design/rgf_pkg.sv
package rgf_pkg;

    // Columns the datapath is built for.
    localparam int MAX_WIDTH = 64;

    // Fixed field widths.
    localparam int ROW_BITS = 64;
    localparam int WIDTH_BITS = 7;

    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(64);
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_CODE = WIDTH_BITS'(MAX_WIDTH);

    typedef logic [ROW_BITS-1:0] row_t;
    typedef logic [WIDTH_BITS-1:0] width_t;

endpackage

>>> design/rgf_pipe_reg.sv
module rgf_pipe_reg
    import rgf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  row_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output row_t out_data
);

    logic valid_reg;
    row_t data_reg;
    logic load;

    // Stage takes a new item whenever it is empty or its item leaves this cycle.
    assign in_ready = !valid_reg || out_ready;
    assign load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

>>> design/rgf_span_fill.sv
module rgf_span_fill
    import rgf_pkg::*;
(
    input  width_t row_width,
    input  row_t   row_bits,
    output row_t   filled_row
);

    localparam int STEPS = $clog2(ROW_BITS);

    width_t eff_width;
    row_t   mask;
    row_t   x;
    row_t   from_first;
    row_t   to_last;

    assign eff_width = (row_width > MAX_WIDTH_CODE) ? MAX_WIDTH_CODE : row_width;

    always_comb
    begin
        for (int i = 0; i < ROW_BITS; i++)
        begin
            mask[i] = (WIDTH_BITS'(i) < eff_width);
        end
    end

    assign x = row_bits & mask;

    // Filling the gaps between first and last run is the same as setting every
    // column from the lowest one to the highest one. Two log-step prefix ORs.
    always_comb
    begin
        from_first = x;
        to_last = x;
        for (int k = 0; k < STEPS; k++)
        begin
            from_first = from_first | (from_first << (1 << k));
            to_last = to_last | (to_last >> (1 << k));
        end
    end

    assign filled_row = from_first & to_last;

endmodule

>>> design/row_gap_fill_between_runs_core.sv
// Channel  Dir  Bus        Fields (low bit up)
// s_*      in   stream     tdata[63:0] row_bits
// m_*      out  stream     tdata[63:0] filled_row
// cfg_*    in   write      cfg_wdata[6:0] row_width
//
// One item per cycle sustained while m_tready holds; two registers (input register, result register).
// The span fill is a single combinational pass between the two registers.
// rst_n clears both stage valids and sets row_width to 64.
// A stalled output holds its item; the input register still takes one more item.
module row_gap_fill_between_runs_core
    import rgf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] row_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] filled_row
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata  // [6:0] row_width
);

    width_t row_width_reg;
    logic   s1_valid;
    logic   s1_ready;
    row_t   s1_data;
    row_t   fill_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            row_width_reg <= cfg_wdata;
        end
    end

    rgf_pipe_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    rgf_span_fill u_fill (
        .row_width  (row_width_reg),
        .row_bits   (s1_data),
        .filled_row (fill_data)
    );

    rgf_pipe_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (fill_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid)
        else $error("accepted item lost in input stage");

    a_stage_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s1_ready |=> m_tvalid)
        else $error("item lost between stages");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && m_tvalid && !m_tready |=> s1_valid && $stable(s1_data))
        else $error("input stage changed under stall");

endmodule

>>> test/tb_row_gap_fill_between_runs_core.sv
module tb_row_gap_fill_between_runs_core
    import rgf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Expected filled rows, in acceptance order, plus a copy of the width register
    class fill_scoreboard;
        width_t row_width;
        row_t   expected_rows[$];
        int     errors;
        int     rows_checked;

        function new();
            row_width = ROW_WIDTH_RESET;
            errors = 0;
            rows_checked = 0;
        endfunction

        function row_t fill_gaps(row_t row);
            int   n;
            int   lo;
            int   hi;
            row_t x;
            row_t filled;
            n = (row_width > MAX_WIDTH) ? MAX_WIDTH : int'(row_width);
            x = (n >= ROW_BITS) ? row : (row & ((row_t'(1) << n) - row_t'(1)));
            filled = x;
            if (x != '0)
            begin
                // first zero after the first run
                lo = 0;
                while (lo < n && !x[lo])
                    lo++;
                while (lo < n && x[lo])
                    lo++;
                // last zero before the last run
                hi = n - 1;
                while (hi >= 0 && !x[hi])
                    hi--;
                while (hi >= 0 && x[hi])
                    hi--;
                for (int i = lo; i <= hi; i++)
                    filled[i] = 1'b1;
            end
            return filled;
        endfunction

        function void note_row(row_t row);
            expected_rows = {expected_rows, fill_gaps(row)};
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_row(row_t got);
            row_t want;
            if (expected_rows.size() == 0)
            begin
                report($sformatf("unexpected item filled_row=%h", got));
            end
            else
            begin
                want = expected_rows.pop_front();
                rows_checked++;
                if (got !== want)
                    report($sformatf("filled_row got %h want %h", got, want));
            end
        endtask

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   s_tvalid;
    logic   s_tready;
    row_t   s_tdata;
    logic   m_tvalid;
    logic   m_tready;
    row_t   m_tdata;
    logic   cfg_we;
    width_t cfg_wdata;

    fill_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int width_settings;

    row_gap_fill_between_runs_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit: far above the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d rows outstanding", sb.pending());
        $display("status: fail");
        $finish;
    end

    // Result side: checks each accepted item, stalls at random, long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_row(m_tdata);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task send_row(row_t row);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= row;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_row(row);
    endtask

    task wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        // two-stage pipeline
        repeat (3) @(posedge clk);
    endtask

    task set_width(width_t w);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.row_width = w;
        width_settings++;
    endtask

    function row_t make_row();
        row_t row;
        int   runs;
        int   start;
        int   len;
        row = '0;
        case ($urandom_range(9))
            0, 1:
                row = {$urandom, $urandom};
            2, 3, 4, 5, 6:
            begin
                runs = $urandom_range(2, 4);
                repeat (runs)
                begin
                    start = $urandom_range(ROW_BITS - 1);
                    len = $urandom_range(1, 12);
                    for (int i = start; i < start + len && i < ROW_BITS; i++)
                        row[i] = 1'b1;
                end
            end
            7:
            begin
                start = $urandom_range(ROW_BITS - 1);
                len = $urandom_range(1, 20);
                for (int i = start; i < start + len && i < ROW_BITS; i++)
                    row[i] = 1'b1;
            end
            8:
            begin
                case ($urandom_range(3))
                    0: row = '0;
                    1: row = '1;
                    default:
                    begin
                        row[$urandom_range(ROW_BITS - 1)] = 1'b1;
                        row[$urandom_range(ROW_BITS - 1)] = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // runs close to the low columns, where narrow widths cut in
                row = {$urandom, $urandom} & row_t'({$urandom} & 32'h0000_0FFF);
                row[$urandom_range(7)] = 1'b1;
            end
        endcase
        return row;
    endfunction

    initial
    begin
        row_t   directed_wide[$];
        row_t   directed_narrow[$];
        width_t widths[$];

        sb = new();
        tx_idle_pct = 24;
        rx_idle_pct = 24;
        hold_cycles = 0;
        width_settings = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full width after reset: empty, full, lone edge bits, edge runs, interior runs, alternating
        directed_wide = '{64'h0, '1, 64'h1, 64'h8000_0000_0000_0000,
                          64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555,
                          64'hAAAA_AAAA_AAAA_AAAA, 64'h00F0_0000_0000_0F00,
                          64'hFFFF_0000_0000_FFFF, 64'h0000_0001_8000_0000,
                          64'h7FFF_FFFF_FFFF_FFFE, 64'h1010_1010_0000_0101,
                          64'hF0F0_F0F0_F0F0_F0F0};
        foreach (directed_wide[i])
            send_row(directed_wide[i]);

        // narrow width: everything beyond the width is dropped
        set_width(7'd8);
        directed_narrow = '{64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_0000_0000_0081,
                            64'h0000_0000_0000_0018, 64'h1234_5678_9ABC_DE5A};
        foreach (directed_narrow[i])
            send_row(directed_narrow[i]);

        // extremes first, saturation above the maximum, then random widths
        widths = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd64, 7'd3};
        repeat (7)
            widths = {widths, width_t'($urandom_range(1, MAX_WIDTH))};

        foreach (widths[p])
        begin
            set_width(widths[p]);
            if (p == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 24;
            end
            if (p == 2)
                hold_cycles = 80;
            for (int k = 0; k < 130; k++)
            begin
                if (p == 6 && k == 65)
                    wait_drain();
                send_row(make_row());
            end
        end

        wait_drain();
        repeat (10) @(posedge clk);
        $display("checked %0d rows across %0d width settings including 0, 1, 64 and 127",
                 sb.rows_checked, width_settings + 1);
        $display("with input and output stalls, a long output hold-off and %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
